FILE: src/sign_magnitude_accumulator_alu_macros.svh
// Assertion macros for the sign-magnitude accumulator ALU.
`ifndef SIGN_MAGNITUDE_ACCUMULATOR_ALU_MACROS_SVH
`define SIGN_MAGNITUDE_ACCUMULATOR_ALU_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SMA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define SMA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sma_alu_pkg.sv
package sma_alu_pkg;

   // Word format: sign bit above MAG_BITS magnitude bits
   localparam int MAG_BITS = 14;
   localparam int WORD_W   = MAG_BITS + 1;
   localparam int PROD_W   = 2 * MAG_BITS;
   localparam int SUM_W    = MAG_BITS + 2;
   localparam int SH_W     = $clog2(MAG_BITS);

   localparam logic [MAG_BITS-1:0] MAG_MASK = '1;

   // Divider: two quotient bits per stage
   localparam int DIV_STAGES = (MAG_BITS + 1) / 2;
   localparam int QW         = 2 * DIV_STAGES;

   // Edges from the accepting edge to the result register
   localparam int PIPE_LAT = DIV_STAGES + 2;

   // Opcodes
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_DIV   = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_SUBC  = 3'd4;
   localparam logic [2:0] OP_LOGLC = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OVF = 2'd1;
   localparam logic [1:0] STATUS_DZ  = 2'd2;
   localparam logic [1:0] STATUS_INV = 2'd3;

   // Per-request control and result carried down the pipe
   typedef struct packed {
      logic              sgn;
      logic [PROD_W-1:0] mag;
      logic              is_div;
      logic              is_subc;
      logic [WORD_W-1:0] mem_word;
      logic [1:0]        fault;
   } lane_type;

   // Restoring divider state
   typedef struct packed {
      logic [MAG_BITS-1:0] rem;
      logic [QW-1:0]       num;
      logic [QW-1:0]       quo;
      logic [MAG_BITS-1:0] den;
   } div_type;

   // Sign-magnitude to two's complement
   function automatic logic signed [SUM_W-1:0] sm_to_int(input logic [WORD_W-1:0] w);
      logic signed [SUM_W-1:0] ext;
      ext = $signed(SUM_W'(w[MAG_BITS-1:0]));
      return w[MAG_BITS] ? -ext : ext;
   endfunction

   // One restoring division step: one quotient bit
   function automatic div_type div_step(input div_type d);
      div_type            r;
      logic [MAG_BITS:0]  trial;
      r     = d;
      trial = {d.rem, d.num[QW-1]};
      r.num = {d.num[QW-2:0], 1'b0};
      if (trial >= {1'b0, d.den}) begin
         r.rem = MAG_BITS'(trial - {1'b0, d.den});
         r.quo = {d.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = trial[MAG_BITS-1:0];
         r.quo = {d.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

FILE: src/sign_magnitude_accumulator_alu.sv
// Sign-magnitude ALU for a 15-bit accumulator machine.
// Request channel: start with req_opcode, req_acc_word, req_mem_word and
// req_indirect_word; a request is taken at each clock edge where start is
// high and busy is low. busy is held low, so a request may enter every cycle.
// Response channel: rsp_valid marks rsp_new_acc, rsp_acc_write and rsp_status
// for one cycle; the receiver cannot hold responses off and none is needed.
// A request passes the input register, the operand stage, 7 divider stages
// and the output stage before the response register loads, and rsp_valid is
// high in the cycle that follows. Throughput is one request per cycle; the
// 7-stage restoring divider, two quotient bits per stage, sets the
// depth. All operations travel the same pipe, so responses leave in request
// order. Multiply uses one 14x14 multiplier in the operand stage.
// Status: 0 ok, 1 overflow, 2 divide by zero, 3 invalid opcode.
// Reset (synchronous, active high) clears every valid bit; requests in flight
// are dropped and no response appears until new requests arrive.
`include "sign_magnitude_accumulator_alu_macros.svh"

module sign_magnitude_accumulator_alu
   import sma_alu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_opcode,
   input  logic [WORD_W-1:0] req_acc_word,
   input  logic [WORD_W-1:0] req_mem_word,
   input  logic [WORD_W-1:0] req_indirect_word,
   output logic              rsp_valid,
   output logic [WORD_W-1:0] rsp_new_acc,
   output logic              rsp_acc_write,
   output logic [1:0]        rsp_status
);

   // Input register
   logic              s0_valid_ff, s0_valid_in;
   logic [2:0]        s0_opcode_ff;
   logic [WORD_W-1:0] s0_acc_ff, s0_mem_ff, s0_ind_ff;

   // Pipe registers: index 0 is the operand stage, then one per divider stage
   logic     valid_ff [DIV_STAGES+1];
   logic     valid_in [DIV_STAGES+1];
   lane_type lane_ff  [DIV_STAGES+1];
   lane_type lane_in  [DIV_STAGES+1];
   div_type  div_ff   [DIV_STAGES+1];
   div_type  div_in   [DIV_STAGES+1];

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_new_acc_ff, rsp_new_acc_in;
   logic              rsp_acc_write_ff, rsp_acc_write_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // Operand stage signals
   logic                    a_sgn, m_sgn;
   logic [MAG_BITS-1:0]     a_mag, m_mag, shifted;
   logic                    shift_ok;
   logic signed [SUM_W-1:0] add_x, add_y, sum;
   logic [SUM_W-2:0]        sum_mag;
   logic [PROD_W-1:0]       prod;

   // Output stage signals
   lane_type          fin_lane;
   logic [PROD_W-1:0] fin_mag;
   logic              fin_over;

   assign busy        = 1'b0;
   assign s0_valid_in = start && !busy;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_opcode_ff <= req_opcode;
      s0_acc_ff    <= req_acc_word;
      s0_mem_ff    <= req_mem_word;
      s0_ind_ff    <= req_indirect_word;
   end

   // Operand stage: add/sub/subc, multiply, shift, divider set-up
   always_comb begin
      a_sgn = s0_acc_ff[MAG_BITS];
      a_mag = s0_acc_ff[MAG_BITS-1:0];
      m_sgn = s0_mem_ff[MAG_BITS];
      m_mag = s0_mem_ff[MAG_BITS-1:0];

      // subc works on memory word minus indirect word
      add_x   = (s0_opcode_ff == OP_SUBC) ? sm_to_int(s0_mem_ff) : sm_to_int(s0_acc_ff);
      add_y   = (s0_opcode_ff == OP_SUBC) ? sm_to_int(s0_ind_ff) : sm_to_int(s0_mem_ff);
      sum     = (s0_opcode_ff == OP_ADD) ? add_x + add_y : add_x - add_y;
      sum_mag = sum[SUM_W-1] ? (SUM_W-1)'(-sum) : sum[SUM_W-2:0];

      prod = PROD_W'(a_mag) * PROD_W'(m_mag);

      // negative zero counts as a shift of zero
      shift_ok = (!a_sgn || (a_mag == '0)) && (a_mag < MAG_BITS'(MAG_BITS));
      shifted  = shift_ok ? (m_mag << a_mag[SH_W-1:0]) : '0;

      lane_in[0]          = '0;
      lane_in[0].mem_word = s0_mem_ff;
      lane_in[0].fault    = STATUS_OK;
      unique case (s0_opcode_ff)
         OP_ADD, OP_SUB, OP_SUBC: begin
            lane_in[0].sgn     = sum[SUM_W-1];
            lane_in[0].mag     = PROD_W'(sum_mag);
            lane_in[0].is_subc = (s0_opcode_ff == OP_SUBC);
         end
         OP_DIV: begin
            lane_in[0].sgn    = a_sgn ^ m_sgn;
            lane_in[0].is_div = 1'b1;
            lane_in[0].fault  = (m_mag == '0) ? STATUS_DZ : STATUS_OK;
         end
         OP_MUL: begin
            lane_in[0].sgn = a_sgn ^ m_sgn;
            lane_in[0].mag = prod;
         end
         OP_LOGLC: begin
            lane_in[0].sgn = m_sgn;
            lane_in[0].mag = PROD_W'(shifted);
         end
         default: begin
            lane_in[0].fault = STATUS_INV;
         end
      endcase

      div_in[0].rem = '0;
      div_in[0].num = QW'(a_mag);
      div_in[0].quo = '0;
      div_in[0].den = m_mag;
      valid_in[0]   = s0_valid_ff;
   end

   // Divider stages: two quotient bits each, other lanes ride along
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      assign div_in[k+1]   = div_step(div_step(div_ff[k]));
      assign lane_in[k+1]  = lane_ff[k];
      assign valid_in[k+1] = valid_ff[k];
   end

   for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         lane_ff[k] <= lane_in[k];
         div_ff[k]  <= div_in[k];
      end
   end

   // Output stage: range check and encode, +0 for zero results
   always_comb begin
      fin_lane     = lane_ff[DIV_STAGES];
      fin_mag      = fin_lane.is_div ? PROD_W'(div_ff[DIV_STAGES].quo) : fin_lane.mag;
      fin_over     = fin_mag > PROD_W'(MAG_MASK);
      rsp_valid_in = valid_ff[DIV_STAGES];
      priority if (fin_lane.fault != STATUS_OK) begin
         rsp_new_acc_in   = '0;
         rsp_acc_write_in = 1'b0;
         rsp_status_in    = fin_lane.fault;
      end else if (fin_over) begin
         // subc has already loaded the memory word
         rsp_new_acc_in   = fin_lane.is_subc ? fin_lane.mem_word : '0;
         rsp_acc_write_in = fin_lane.is_subc;
         rsp_status_in    = STATUS_OVF;
      end else begin
         rsp_new_acc_in   = {fin_lane.sgn && (fin_mag[MAG_BITS-1:0] != '0),
                             fin_mag[MAG_BITS-1:0]};
         rsp_acc_write_in = 1'b1;
         rsp_status_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_new_acc_ff   <= rsp_new_acc_in;
      rsp_acc_write_ff <= rsp_acc_write_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_acc   = rsp_new_acc_ff;
   assign rsp_acc_write = rsp_acc_write_ff;
   assign rsp_status    = rsp_status_ff;

   // Checks: a response is seen after the response register loads
   `SMA_ASSERT_IMP(a_rsp_follows_req, clock, reset, rsp_valid,
      $past(start && !busy && !reset, PIPE_LAT + 1), "response without a matching request")
   `SMA_ASSERT_IMP(a_fault_no_write, clock, reset,
      rsp_valid && (rsp_status == STATUS_DZ || rsp_status == STATUS_INV),
      !rsp_acc_write && (rsp_new_acc == '0), "fault wrote the accumulator")
   `SMA_ASSERT_IMP(a_no_neg_zero, clock, reset,
      rsp_valid && rsp_acc_write && (rsp_status == STATUS_OK),
      !(rsp_new_acc[MAG_BITS] && (rsp_new_acc[MAG_BITS-1:0] == '0)), "negative zero result")
   `SMA_ASSERT_IMP(a_div_rem_range, clock, reset,
      valid_ff[DIV_STAGES] && lane_ff[DIV_STAGES].is_div &&
      (lane_ff[DIV_STAGES].fault == STATUS_OK),
      div_ff[DIV_STAGES].rem < div_ff[DIV_STAGES].den, "divider remainder not below divisor")

endmodule

FILE: bench/tb_sign_magnitude_accumulator_alu.sv
module tb_sign_magnitude_accumulator_alu
   import sma_alu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Opcodes that the block must reject
   localparam logic [2:0] OP_RESERVED_LO = 3'd6;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   // Cycles with no request taken and no response seen before giving up
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [WORD_W-1:0] new_acc;
      logic              acc_write;
      logic [1:0]        status;
   } alu_result_type;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              start             = 1'b0;
   logic              busy;
   logic [2:0]        req_opcode        = '0;
   logic [WORD_W-1:0] req_acc_word      = '0;
   logic [WORD_W-1:0] req_mem_word      = '0;
   logic [WORD_W-1:0] req_indirect_word = '0;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_new_acc;
   logic              rsp_acc_write;
   logic [1:0]        rsp_status;

   alu_result_type expected_results[$];
   int             mismatch_count = 0;
   int             response_count = 0;
   int             sender_idle_pct = 0;

   sign_magnitude_accumulator_alu dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_acc_word      (req_acc_word),
      .req_mem_word      (req_mem_word),
      .req_indirect_word (req_indirect_word),
      .rsp_valid         (rsp_valid),
      .rsp_new_acc       (rsp_new_acc),
      .rsp_acc_write     (rsp_acc_write),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   // Sign-magnitude word to signed integer; negative zero reads as 0
   function automatic longint word_value(input logic [WORD_W-1:0] w);
      longint mag;
      mag = longint'(w[MAG_BITS-1:0]);
      return w[MAG_BITS] ? -mag : mag;
   endfunction

   // Expected accumulator update for one request
   function automatic alu_result_type predict_alu(input logic [2:0] op,
                                                  input logic [WORD_W-1:0] acc,
                                                  input logic [WORD_W-1:0] mem,
                                                  input logic [WORD_W-1:0] ind);
      alu_result_type      res;
      longint              a;
      longint              m;
      longint              r;
      longint              lim;
      logic [MAG_BITS-1:0] shifted;
      res     = '0;
      a       = word_value(acc);
      m       = word_value(mem);
      lim     = (longint'(1) << MAG_BITS) - 1;
      r       = 0;
      shifted = '0;
      case (op)
         OP_ADD: r = a + m;
         OP_SUB: r = a - m;
         OP_DIV: begin
            if (m == 0) begin
               res.status = STATUS_DZ;
               return res;
            end
            r = a / m;
         end
         OP_MUL:  r = a * m;
         OP_SUBC: r = m - word_value(ind);
         OP_LOGLC: begin
            // shift counts below zero or past the magnitude clear it
            if (a >= 0 && a < MAG_BITS)
               shifted = mem[MAG_BITS-1:0] << a;
            r = mem[MAG_BITS] ? -longint'(shifted) : longint'(shifted);
         end
         default: begin
            res.status = STATUS_INV;
            return res;
         end
      endcase
      if (r > lim || r < -lim) begin
         res.status = STATUS_OVF;
         // subc has already loaded the memory word
         if (op == OP_SUBC) begin
            res.acc_write = 1'b1;
            res.new_acc   = mem;
         end
      end else begin
         res.status    = STATUS_OK;
         res.acc_write = 1'b1;
         res.new_acc   = (r < 0) ? {1'b1, MAG_BITS'(-r)} : WORD_W'(r);
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("[%0t] %s", $realtime, what);
   endtask

   // Drive one request at the falling edge, hold it until taken
   task automatic send_request(input logic [2:0] op,
                               input logic [WORD_W-1:0] acc,
                               input logic [WORD_W-1:0] mem,
                               input logic [WORD_W-1:0] ind);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_acc_word      <= acc;
      req_mem_word      <= mem;
      req_indirect_word <= ind;
      do
         @(posedge clock);
      while (busy);
      expected_results.push_back(predict_alu(op, acc, mem, ind));
   endtask

   // Random word: full range, small, mid, extremes and zeros
   function automatic logic [WORD_W-1:0] rand_word();
      logic sgn;
      sgn = $urandom_range(1);
      case ($urandom_range(9))
         0, 1, 2, 3: return WORD_W'($urandom);
         4, 5, 6:    return {sgn, MAG_BITS'($urandom_range(127))};
         7:          return {sgn, MAG_BITS'($urandom_range(16'h3FF))};
         8:          return {sgn, $urandom_range(1) ? MAG_MASK : MAG_BITS'(1)};
         default:    return {sgn, MAG_BITS'(0)};
      endcase
   endfunction

   // Response checker: in-order compare against the oldest prediction
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_valid) begin
         response_count++;
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("response %0d with none pending: new_acc=%h write=%b status=%0d",
                                    response_count, rsp_new_acc, rsp_acc_write, rsp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_new_acc !== want.new_acc || rsp_acc_write !== want.acc_write ||
                rsp_status !== want.status)
               note_mismatch($sformatf({"response %0d: expected new_acc=%h write=%b status=%0d,",
                                        " got new_acc=%h write=%b status=%0d"},
                                       response_count, want.new_acc, want.acc_write,
                                       want.status, rsp_new_acc, rsp_acc_write, rsp_status));
         end
      end
   end

   // Watchdog: too long with no request taken and no response
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (!reset && ((start && !busy) || rsp_valid))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Add and subtract at the range limits, zero results as +0
   task automatic test_add_sub_extremes();
      send_request(OP_ADD, 15'h3FFF, 15'h0001, 15'h0000);
      send_request(OP_ADD, 15'h3FFF, 15'h7FFF, 15'h7FFF);
      send_request(OP_ADD, 15'h4000, 15'h4000, 15'h0000);
      send_request(OP_ADD, 15'h7FFF, 15'h7FFF, 15'h3FFF);
      send_request(OP_SUB, 15'h3FFF, 15'h7FFF, 15'h0000);
      send_request(OP_SUB, 15'h0005, 15'h0005, 15'h7FFF);
      send_request(OP_SUB, 15'h4001, 15'h3FFE, 15'h0000);
   endtask

   // Divide by +0 and -0, truncation toward zero, largest quotient
   task automatic test_divide();
      send_request(OP_DIV, 15'h3FFF, 15'h4000, 15'h0000);
      send_request(OP_DIV, 15'h1234, 15'h0000, 15'h7FFF);
      send_request(OP_DIV, 15'h4007, 15'h0002, 15'h0000);
      send_request(OP_DIV, 15'h7FFF, 15'h4001, 15'h0000);
      send_request(OP_DIV, 15'h0007, 15'h4002, 15'h0000);
   endtask

   // Products either side of the limit, negative zero times a positive word
   task automatic test_multiply();
      send_request(OP_MUL, 15'h007F, 15'h0081, 15'h0000);
      send_request(OP_MUL, 15'h0080, 15'h0080, 15'h0000);
      send_request(OP_MUL, 15'h7FFF, 15'h4001, 15'h0000);
      send_request(OP_MUL, 15'h4000, 15'h3FFF, 15'h0000);
   endtask

   // subc overflow keeps the memory word written
   task automatic test_subc();
      send_request(OP_SUBC, 15'h0000, 15'h3FFF, 15'h7FFF);
      send_request(OP_SUBC, 15'h7FFF, 15'h4005, 15'h4005);
      send_request(OP_SUBC, 15'h2AAA, 15'h0001, 15'h3FFF);
   endtask

   // Shift counts in range, at the top, negative, and negative zero
   task automatic test_loglc();
      send_request(OP_LOGLC, 15'h0000, 15'h7FFF, 15'h0000);
      send_request(OP_LOGLC, 15'h000D, 15'h0001, 15'h0000);
      send_request(OP_LOGLC, 15'h000E, 15'h7FFF, 15'h0000);
      send_request(OP_LOGLC, 15'h4001, 15'h3FFF, 15'h0000);
      send_request(OP_LOGLC, 15'h4000, 15'h4003, 15'h0000);
      send_request(OP_LOGLC, 15'h0003, 15'h7FFF, 15'h7FFF);
   endtask

   task automatic test_invalid_opcodes();
      send_request(OP_RESERVED_LO, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      send_request(OP_RESERVED_HI, 15'h3FFF, 15'h0001, 15'h4000);
   endtask

   // Mostly valid operations; loglc counts kept near the useful range
   task automatic test_random(input int count, input int idle_pct);
      logic [2:0]        op;
      logic [WORD_W-1:0] acc;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         if ($urandom_range(9) == 0)
            op = $urandom_range(1) ? OP_RESERVED_HI : OP_RESERVED_LO;
         else
            op = 3'($urandom_range(5));
         acc = rand_word();
         if (op == OP_LOGLC && $urandom_range(3) != 0)
            acc = {1'($urandom_range(1)), MAG_BITS'($urandom_range(MAG_BITS + 1))};
         send_request(op, acc, rand_word(), rand_word());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 30;
      test_add_sub_extremes();
      test_divide();
      test_multiply();
      test_subc();
      test_loglc();
      test_invalid_opcodes();

      test_random(200, 0);
      test_random(200, 73);
      test_random(200, 15);
      test_random(200, 0);

      @(negedge clock);
      start <= 1'b0;

      // drain the pipe, then a margin for stray responses
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);

      if (expected_results.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", expected_results.size()));

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/sma_alu_pkg.sv
src/sign_magnitude_accumulator_alu.sv
bench/tb_sign_magnitude_accumulator_alu.sv
